// ===== rtl/core/kl_pkg.sv =====
// Shared types, token codes and the reserved-word table for the keyword lexer.
// Used by kl_ctrl, kl_dp and keyword_lexer_core; depends on nothing else.

package kl_pkg;

  localparam int unsigned MAX_LEXEME_DEF = 32;
  localparam int unsigned KW_COUNT       = 24;
  localparam int unsigned KW_MAX_LEN     = 9;

  // Token codes
  localparam logic [5:0] TK_BEGIN     = 6'd0;
  localparam logic [5:0] TK_END       = 6'd1;
  localparam logic [5:0] TK_READ      = 6'd2;
  localparam logic [5:0] TK_WRITE     = 6'd3;
  localparam logic [5:0] TK_ID        = 6'd4;
  localparam logic [5:0] TK_INTLIT    = 6'd5;
  localparam logic [5:0] TK_LPAREN    = 6'd6;
  localparam logic [5:0] TK_RPAREN    = 6'd7;
  localparam logic [5:0] TK_SEMI      = 6'd8;
  localparam logic [5:0] TK_COMMA     = 6'd9;
  localparam logic [5:0] TK_ASSIGN    = 6'd10;
  localparam logic [5:0] TK_PLUS      = 6'd11;
  localparam logic [5:0] TK_MINUS     = 6'd12;
  localparam logic [5:0] TK_OR        = 6'd13;
  localparam logic [5:0] TK_AND       = 6'd14;
  localparam logic [5:0] TK_EQU       = 6'd15;
  localparam logic [5:0] TK_IF        = 6'd16;
  localparam logic [5:0] TK_ELSE      = 6'd17;
  localparam logic [5:0] TK_RETURN    = 6'd18;
  localparam logic [5:0] TK_FUNCTION  = 6'd19;
  localparam logic [5:0] TK_COLON     = 6'd20;
  localparam logic [5:0] TK_RANGE     = 6'd21;
  localparam logic [5:0] TK_RANDG     = 6'd22;
  localparam logic [5:0] TK_RANDL     = 6'd23;
  localparam logic [5:0] TK_ROUTE     = 6'd24;
  localparam logic [5:0] TK_EXISTS    = 6'd25;
  localparam logic [5:0] TK_TAKER     = 6'd26;
  localparam logic [5:0] TK_WAIT      = 6'd27;
  localparam logic [5:0] TK_MSG       = 6'd28;
  localparam logic [5:0] TK_CASE      = 6'd29;
  localparam logic [5:0] TK_SWITCH    = 6'd30;
  localparam logic [5:0] TK_BREAK     = 6'd31;
  localparam logic [5:0] TK_ADDR      = 6'd32;
  localparam logic [5:0] TK_GETROUTE  = 6'd33;
  localparam logic [5:0] TK_GETLEADER = 6'd34;
  localparam logic [5:0] TK_GETOBJECT = 6'd35;
  localparam logic [5:0] TK_INT       = 6'd37;
  localparam logic [5:0] TK_FOR       = 6'd38;
  localparam logic [5:0] TK_EOF       = 6'd40;
  localparam logic [5:0] TK_ERROR     = 6'd41;

  localparam logic [30:0] LIT_MAX  = 31'h7FFF_FFFF;
  localparam logic [23:0] LINE_MAX = 24'hFF_FFFF;

  // Source bytes with a meaning of their own
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = "#";
  localparam logic [7:0] CH_SLASH  = "/";
  localparam logic [7:0] CH_EQUAL  = "=";
  localparam logic [7:0] CH_UNDER  = "_";
  localparam logic [7:0] CH_LPAREN = "(";
  localparam logic [7:0] CH_RPAREN = ")";
  localparam logic [7:0] CH_SEMI   = ";";
  localparam logic [7:0] CH_COMMA  = ",";
  localparam logic [7:0] CH_AT     = "@";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_BAR    = "|";
  localparam logic [7:0] CH_AMP    = "&";
  localparam logic [7:0] CH_LBRACE = "{";
  localparam logic [7:0] CH_RBRACE = "}";
  localparam logic [7:0] CH_COLON  = ":";

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [7:0]  lexeme_char;
    logic [5:0]  lexeme_length;
    logic [30:0] literal_value;
    logic [23:0] line_number;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_FUNC,
    MODE_DIGITS,
    MODE_COMMENT,
    MODE_SLASH,
    MODE_EQUAL
  } mode_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_FLUSH,
    S_FLUSH_PUT,
    S_MATCH_RD,
    S_MATCH_CMP,
    S_MATCH_END,
    S_TEXT_RD,
    S_TEXT_PUT,
    S_EQU_PUT,
    S_AFTER,
    S_SCAN,
    S_EOF_PUT
  } state_e;

  typedef enum logic [2:0] {
    OSEL_SCAN,
    OSEL_FLUSH,
    OSEL_TEXT,
    OSEL_EQU,
    OSEL_EOF
  } out_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     absorb;
    logic     scan;
    logic     mode_idle;
    logic     set_ended;
    logic     idx_clr;
    logic     idx_inc;
    logic     mask_init;
    logic     mask_step;
    logic     out_load;
    out_sel_e out_sel;
  } cmd_t;

  typedef struct packed {
    logic  ended;
    logic  eof;
    logic  absorb_ok;
    logic  equ_pair;
    mode_e mode;
    logic  kw_possible;
    logic  kw_hit;
    logic  idx_last;
    logic  scan_emits;
    logic  out_free;
  } status_t;

  typedef struct packed {
    logic [71:0] text;   // left aligned, zero padded
    logic [3:0]  len;
    logic [5:0]  kind;
  } kw_entry_t;

  function automatic kw_entry_t kw_entry(input logic [4:0] idx);
    kw_entry_t e;
    e = '0;
    unique case (idx)
      5'd0:  e = '{text: {"BEGIN", 32'h0},    len: 4'd5, kind: TK_BEGIN};
      5'd1:  e = '{text: {"END", 48'h0},      len: 4'd3, kind: TK_END};
      5'd2:  e = '{text: {"READ", 40'h0},     len: 4'd4, kind: TK_READ};
      5'd3:  e = '{text: {"FUNCTION", 8'h0},  len: 4'd8, kind: TK_FUNCTION};
      5'd4:  e = '{text: {"IF", 56'h0},       len: 4'd2, kind: TK_IF};
      5'd5:  e = '{text: {"ELSE", 40'h0},     len: 4'd4, kind: TK_ELSE};
      5'd6:  e = '{text: {"SWITCH", 24'h0},   len: 4'd6, kind: TK_SWITCH};
      5'd7:  e = '{text: {"CASE", 40'h0},     len: 4'd4, kind: TK_CASE};
      5'd8:  e = '{text: {"BREAK", 32'h0},    len: 4'd5, kind: TK_BREAK};
      5'd9:  e = '{text: {"RETURN", 24'h0},   len: 4'd6, kind: TK_RETURN};
      5'd10: e = '{text: {"RANGE", 32'h0},    len: 4'd5, kind: TK_RANGE};
      5'd11: e = '{text: {"RANDG", 32'h0},    len: 4'd5, kind: TK_RANDG};
      5'd12: e = '{text: {"RANDL", 32'h0},    len: 4'd5, kind: TK_RANDL};
      5'd13: e = '{text: {"EXISTS", 24'h0},   len: 4'd6, kind: TK_EXISTS};
      5'd14: e = '{text: {"ROUTE", 32'h0},    len: 4'd5, kind: TK_ROUTE};
      5'd15: e = '{text: {"TAKER", 32'h0},    len: 4'd5, kind: TK_TAKER};
      5'd16: e = '{text: {"WAIT", 40'h0},     len: 4'd4, kind: TK_WAIT};
      5'd17: e = '{text: {"MSG", 48'h0},      len: 4'd3, kind: TK_MSG};
      5'd18: e = '{text: {"INT", 48'h0},      len: 4'd3, kind: TK_INT};
      5'd19: e = '{text: {"GETROUTE", 8'h0},  len: 4'd8, kind: TK_GETROUTE};
      5'd20: e = '{text: "GETOBJECT",         len: 4'd9, kind: TK_GETOBJECT};
      5'd21: e = '{text: "GETLEADER",         len: 4'd9, kind: TK_GETLEADER};
      5'd22: e = '{text: {"FOR", 48'h0},      len: 4'd3, kind: TK_FOR};
      5'd23: e = '{text: {"WRITE", 32'h0},    len: 4'd5, kind: TK_WRITE};
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= "A") && (b <= "Z")) || ((b >= "a") && (b <= "z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) ? (b - 8'd32) : b;
  endfunction

endpackage

// ===== rtl/core/kl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.

module kl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/kl_ctrl.sv =====
// Sequencer of the keyword lexer: walks each item through dispatch, flush,
// keyword match, text replay and scan. Uses kl_pkg.

module kl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  kl_pkg::status_t status_i,
  output kl_pkg::cmd_t    cmd_o
);
  import kl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (status_i.ended) begin
          state_d = S_EOF_PUT;
        end else if (status_i.eof) begin
          state_d = S_FLUSH;
        end else if (status_i.absorb_ok) begin
          cmd_o.absorb = 1'b1;
          state_d      = S_IDLE;
        end else if (status_i.equ_pair) begin
          state_d = S_EQU_PUT;
        end else if (status_i.mode == MODE_IDLE) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        unique case (status_i.mode)
          MODE_WORD: begin
            cmd_o.idx_clr = 1'b1;
            if (status_i.kw_possible) begin
              cmd_o.mask_init = 1'b1;
              state_d         = S_MATCH_RD;
            end else begin
              state_d = S_TEXT_RD;
            end
          end
          MODE_FUNC: begin
            cmd_o.idx_clr = 1'b1;
            state_d       = S_TEXT_RD;
          end
          MODE_DIGITS, MODE_SLASH, MODE_EQUAL: begin
            state_d = S_FLUSH_PUT;
          end
          default: begin
            // nothing pending; an open comment just closes
            cmd_o.mode_idle = 1'b1;
            state_d         = S_AFTER;
          end
        endcase
      end
      S_FLUSH_PUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = OSEL_FLUSH;
          cmd_o.mode_idle = 1'b1;
          state_d         = S_AFTER;
        end
      end
      S_MATCH_RD: begin
        state_d = S_MATCH_CMP;
      end
      S_MATCH_CMP: begin
        cmd_o.mask_step = 1'b1;
        if (status_i.idx_last) begin
          state_d = S_MATCH_END;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_MATCH_RD;
        end
      end
      S_MATCH_END: begin
        if (status_i.kw_hit) begin
          state_d = S_FLUSH_PUT;
        end else begin
          cmd_o.idx_clr = 1'b1;
          state_d       = S_TEXT_RD;
        end
      end
      S_TEXT_RD: begin
        state_d = S_TEXT_PUT;
      end
      S_TEXT_PUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = OSEL_TEXT;
          if (status_i.idx_last) begin
            cmd_o.mode_idle = 1'b1;
            state_d         = S_AFTER;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_TEXT_RD;
          end
        end
      end
      S_EQU_PUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = OSEL_EQU;
          cmd_o.mode_idle = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_AFTER: begin
        state_d = status_i.eof ? S_EOF_PUT : S_SCAN;
      end
      S_SCAN: begin
        if (!status_i.scan_emits || status_i.out_free) begin
          cmd_o.scan     = 1'b1;
          cmd_o.out_load = status_i.scan_emits;
          cmd_o.out_sel  = OSEL_SCAN;
          state_d        = S_IDLE;
        end
      end
      S_EOF_PUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = OSEL_EOF;
          cmd_o.set_ended = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/kl_dp.sv =====
// Datapath of the keyword lexer: item register, scan state, lexeme RAM,
// keyword match mask and the output register. Uses kl_pkg and kl_ram.

module kl_dp #(
  parameter int unsigned MAX_LEXEME = kl_pkg::MAX_LEXEME_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kl_pkg::in_item_t  in_item_i,
  input  kl_pkg::cmd_t      cmd_i,
  output kl_pkg::status_t   status_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kl_pkg::out_item_t out_item_o
);
  import kl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_LEXEME);
  localparam int unsigned CW = $clog2(MAX_LEXEME + 1);

  logic [7:0]          byte_q;
  logic                eof_q;
  logic                ended_q, ended_d;
  mode_e               mode_q, mode_d;
  logic [CW-1:0]       count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [30:0]         acc_q, acc_d;
  logic [23:0]         line_q, line_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [KW_COUNT-1:0] mask_q, mask_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [7:0]          rdata;

  logic                is_word_start, is_func_start, is_newline, is_blank;
  logic                scan_emits;
  logic [5:0]          scan_kind;
  logic [5:0]          kw_kind;
  logic                idx_last;
  logic                out_free;
  logic [34:0]         acc_next;
  logic [71:0]         kw_shift;
  logic                do_append;
  logic                do_start;
  mode_e               start_mode;
  kw_entry_t           kw_tab [KW_COUNT];

  kl_ram #(
    .WIDTH (8),
    .DEPTH (MAX_LEXEME)
  ) u_lexeme_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (byte_q),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Reserved-word table as constant logic
  for (genvar g = 0; g < KW_COUNT; g++) begin : g_kw
    assign kw_tab[g] = kw_entry(5'(g));
  end

  // Byte classes and the single-byte token decode
  always_comb begin
    is_newline    = (byte_q == CH_LF) || (byte_q == CH_CR);
    is_blank      = (byte_q == CH_TAB) || (byte_q == CH_VT) ||
                    (byte_q == CH_FF) || (byte_q == CH_SPACE);
    is_word_start = is_alpha(byte_q);
    is_func_start = (byte_q == CH_UNDER);
    unique case (byte_q)
      CH_LPAREN: scan_kind = TK_LPAREN;
      CH_RPAREN: scan_kind = TK_RPAREN;
      CH_SEMI:   scan_kind = TK_SEMI;
      CH_COMMA:  scan_kind = TK_COMMA;
      CH_AT:     scan_kind = TK_ADDR;
      CH_PLUS:   scan_kind = TK_PLUS;
      CH_MINUS:  scan_kind = TK_MINUS;
      CH_BAR:    scan_kind = TK_OR;
      CH_AMP:    scan_kind = TK_AND;
      CH_LBRACE: scan_kind = TK_BEGIN;
      CH_RBRACE: scan_kind = TK_END;
      CH_COLON:  scan_kind = TK_COLON;
      default:   scan_kind = TK_ERROR;
    endcase
    scan_emits = !(is_newline || is_blank || is_word_start || is_func_start ||
                   is_digit(byte_q) || (byte_q == CH_HASH) ||
                   (byte_q == CH_SLASH) || (byte_q == CH_EQUAL));
  end

  // Lowest table index wins; reserved words never collide anyway
  always_comb begin
    kw_kind = TK_ID;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        kw_kind = kw_tab[i].kind;
      end
    end
  end

  assign idx_last = ((CW'(idx_q) + CW'(1)) == count_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign acc_next = (35'(acc_q) << 3) + (35'(acc_q) << 1) + 35'(byte_q[3:0]);

  // Scan state update
  always_comb begin
    ended_d    = ended_q || cmd_i.set_ended;
    mode_d     = mode_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    acc_d      = acc_q;
    line_d     = line_q;
    do_append  = 1'b0;
    do_start   = 1'b0;
    start_mode = MODE_WORD;
    we         = 1'b0;
    waddr      = count_q[AW-1:0];

    if (cmd_i.absorb) begin
      case (mode_q)
        MODE_WORD, MODE_FUNC: do_append = 1'b1;
        MODE_DIGITS: begin
          if (count_q < CW'(MAX_LEXEME)) begin
            count_d = count_q + CW'(1);
          end
          acc_d = (acc_next > 35'(LIT_MAX)) ? LIT_MAX : acc_next[30:0];
        end
        MODE_SLASH: mode_d = MODE_COMMENT;
        default: ;
      endcase
    end

    if (cmd_i.scan) begin
      mode_d = MODE_IDLE;
      if (is_newline) begin
        if (line_q != LINE_MAX) begin
          line_d = line_q + 24'd1;
        end
      end else if (is_word_start) begin
        do_start   = 1'b1;
        start_mode = MODE_WORD;
      end else if (is_func_start) begin
        do_start   = 1'b1;
        start_mode = MODE_FUNC;
      end else if (is_digit(byte_q)) begin
        mode_d  = MODE_DIGITS;
        count_d = CW'(1);
        acc_d   = 31'(byte_q[3:0]);
      end else if (byte_q == CH_HASH) begin
        mode_d = MODE_COMMENT;
      end else if (byte_q == CH_SLASH) begin
        mode_d = MODE_SLASH;
      end else if (byte_q == CH_EQUAL) begin
        mode_d = MODE_EQUAL;
      end
    end

    if (do_start) begin
      mode_d  = start_mode;
      count_d = CW'(1);
      ovf_d   = 1'b0;
      we      = 1'b1;
      waddr   = '0;
    end

    if (do_append) begin
      if (count_q < CW'(MAX_LEXEME)) begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end

    if (cmd_i.mode_idle) begin
      mode_d = MODE_IDLE;
    end
  end

  // Index and keyword candidate mask
  always_comb begin
    idx_d    = idx_q;
    mask_d   = mask_q;
    kw_shift = '0;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + AW'(1);
    end
    for (int i = 0; i < KW_COUNT; i++) begin
      kw_shift = kw_tab[i].text << {idx_q[3:0], 3'b000};
      if (cmd_i.mask_init) begin
        mask_d[i] = (CW'(kw_tab[i].len) == count_q);
      end else if (cmd_i.mask_step) begin
        mask_d[i] = mask_q[i] && (kw_shift[71:64] == to_upper(rdata));
      end
    end
  end

  // Result build
  always_comb begin
    out_d             = '0;
    out_d.line_number = line_q;
    out_d.last        = 1'b1;
    case (cmd_i.out_sel)
      OSEL_SCAN: begin
        out_d.token_kind  = scan_kind;
        out_d.lexeme_char = (scan_kind == TK_ERROR) ? byte_q : 8'h00;
      end
      OSEL_FLUSH: begin
        case (mode_q)
          MODE_WORD: begin
            out_d.token_kind    = kw_kind;
            out_d.lexeme_length = 6'(count_q);
          end
          MODE_DIGITS: begin
            out_d.token_kind    = TK_INTLIT;
            out_d.lexeme_length = 6'(count_q);
            out_d.literal_value = acc_q;
          end
          MODE_SLASH: out_d.token_kind = TK_PLUS;
          default:    out_d.token_kind = TK_ASSIGN;
        endcase
      end
      OSEL_TEXT: begin
        out_d.token_kind    = (mode_q == MODE_FUNC) ? TK_FUNCTION : TK_ID;
        out_d.lexeme_char   = rdata;
        out_d.lexeme_length = 6'(count_q);
        out_d.last          = idx_last;
      end
      OSEL_EQU: out_d.token_kind = TK_EQU;
      default:  out_d.token_kind = TK_EOF;
    endcase
    out_valid_d = cmd_i.out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_q     <= 1'b0;
      mode_q      <= MODE_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      acc_q       <= '0;
      line_q      <= '0;
      idx_q       <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ended_q     <= ended_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      acc_q       <= acc_d;
      line_q      <= line_d;
      idx_q       <= idx_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      byte_q <= in_item_i.in_byte;
      eof_q  <= in_item_i.end_of_input;
    end
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    status_o.ended       = ended_q;
    status_o.eof         = eof_q;
    status_o.mode        = mode_q;
    status_o.equ_pair    = (mode_q == MODE_EQUAL) && (byte_q == CH_EQUAL);
    status_o.kw_possible = !ovf_q && (count_q <= CW'(KW_MAX_LEN));
    status_o.kw_hit      = |mask_q;
    status_o.idx_last    = idx_last;
    status_o.scan_emits  = scan_emits;
    status_o.out_free    = out_free;
    case (mode_q)
      MODE_WORD:    status_o.absorb_ok = is_alpha(byte_q) || is_digit(byte_q) ||
                                         (byte_q == CH_UNDER);
      MODE_FUNC:    status_o.absorb_ok = is_alpha(byte_q);
      MODE_DIGITS:  status_o.absorb_ok = is_digit(byte_q);
      MODE_COMMENT: status_o.absorb_ok = (byte_q != CH_LF);
      MODE_SLASH:   status_o.absorb_ok = (byte_q == CH_SLASH);
      default:      status_o.absorb_ok = 1'b0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/core/keyword_lexer_core.sv =====
// Top level of the keyword lexer: byte stream in, token items out.
// Joins kl_ctrl and kl_dp; uses kl_pkg.
//
// Input channel: one source byte per item (in_valid_i / in_stall_o), with
// end_of_input marking the end of the source. Output channel: token items
// (out_valid_o / out_stall_i); identifiers and function words arrive as a
// run of items, one kept byte each, with last set on the final one.
// A byte that extends the current word, literal or comment passes through
// the dispatch state only. A word that ends is checked against the reserved
// words one byte at a time, in a read and a compare state (only for words of
// at most nine bytes), and an identifier is replayed one byte at a time, in a
// read and a put state; both are bound by the one read port of the lexeme RAM.
// Input is taken only while the sequencer is idle, but a finished result may
// still wait in the output register while the next byte is taken.
// A stalled receiver holds the output register; the sequencer waits only
// when it has a further result to load.
// Reset clears the scan mode, counters, line count and end flag at once;
// the lexeme RAM is not cleared and needs no clearing pass.
// After end of input every further item answers with a single end token.

module keyword_lexer_core #(
  parameter int unsigned MAX_LEXEME = kl_pkg::MAX_LEXEME_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  kl_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output kl_pkg::out_item_t out_item_o
);
  import kl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer: decides what each accepted item does and in which order the
  // results leave.
  kl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: scan state, lexeme RAM, keyword mask and output register.
  kl_dp #(
    .MAX_LEXEME (MAX_LEXEME)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // An accepted item always keeps the sequencer busy for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken on two consecutive cycles");

  // Only identifier and function runs span more than one result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.last) |->
      (out_item_o.token_kind == TK_ID || out_item_o.token_kind == TK_FUNCTION))
    else $error("multi-item run with a kind other than identifier or function");

  // Lengths never pass the lexeme limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.lexeme_length <= 6'(MAX_LEXEME)))
    else $error("lexeme length beyond limit");

endmodule
